// ----- sv/olar_pkg.sv -----
package olar_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 6;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // broadcast command seen by every cell of the chain
  typedef enum logic [1:0] {
    CMD_IDLE   = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_ROTATE = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [CNT_W-1:0]   count;
    logic [CNT_W-1:0]   pos;
    logic signed [31:0] data;
  } cell_cmd_t;

endpackage

// ----- sv/ordered_list_append_remove.sv -----
// append and remove give their single result in the cycle after the item is accepted
// throughput: append and remove take one item per cycle while busy is low; a dump of n
//   entries holds busy until it ends and gives one result per cycle, once dumping is set
// results come from registers and are shown for one cycle only; the receiver cannot stall
// reset (rst, synchronous) empties the list and clears busy and done; entry storage is
//   not cleared, since only entries below the count are ever read
module ordered_list_append_remove (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic signed [31:0]          new_value,
  input  logic [olar_pkg::POS_W-1:0]  position,
  output logic                        done,
  output logic [1:0]                  status,
  output logic signed [31:0]          out_value,
  output logic [olar_pkg::POS_W-1:0]  out_index,
  output logic                        last
);
  import olar_pkg::*;

  // list state: entry count plus dump sequencer
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             dumping;
  logic             dumping_next;
  logic [IDX_W-1:0] dcnt;
  logic [IDX_W-1:0] dcnt_next;

  // result to be registered at the coming edge
  logic               res_fire;
  status_t            res_status;
  logic signed [31:0] res_value;
  logic [POS_W-1:0]   res_index;
  logic               res_last;

  logic               accept;
  logic               dump_last;
  cell_cmd_t          cmd;
  logic signed [31:0] cell_value [CAPACITY];

  assign accept    = start && !busy;
  assign busy      = dumping;
  assign dump_last = ((CNT_W'(dcnt) + CNT_W'(1)) == count);

  // chain of cells, each hands its value to the one before it
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] nbr;
    if (g + 1 < CAPACITY) begin : g_mid
      assign nbr = cell_value[g + 1];
    end else begin : g_end
      assign nbr = '0;
    end
    olar_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (CNT_W'(g)),
      .next_value (nbr),
      .wrap_value (cell_value[0]),
      .value      (cell_value[g])
    );
  end

  always_comb begin
    cmd          = '{op: CMD_IDLE, count: count, pos: '0, data: new_value};
    count_next   = count;
    dumping_next = dumping;
    dcnt_next    = dcnt;
    res_fire     = 1'b0;
    res_status   = ST_OK;
    res_value    = '0;
    res_index    = '0;
    res_last     = 1'b1;
    if (dumping) begin
      // head of the chain is the current entry, then the chain turns
      cmd.op     = CMD_ROTATE;
      res_fire   = 1'b1;
      res_value  = cell_value[0];
      res_index  = POS_W'(dcnt);
      res_last   = dump_last;
      if (dump_last) begin
        dumping_next = 1'b0;
        dcnt_next    = '0;
      end else begin
        dcnt_next = dcnt + IDX_W'(1);
      end
    end else if (accept) begin
      unique case (opcode)
        OP_APPEND: begin
          res_fire = 1'b1;
          if (count == CNT_W'(CAPACITY)) begin
            res_status = ST_FULL;
          end else begin
            cmd.op     = CMD_APPEND;
            count_next = count + CNT_W'(1);
          end
        end
        OP_REMOVE: begin
          res_fire = 1'b1;
          if (count == '0) begin
            res_status = ST_EMPTY;
          end else if (CMP_W'(position) >= CMP_W'(count)) begin
            res_status = ST_BADPOS;
          end else begin
            cmd.op     = CMD_REMOVE;
            cmd.pos    = CNT_W'(position);
            res_value  = cell_value[IDX_W'(position)];
            count_next = count - CNT_W'(1);
          end
        end
        OP_DUMP: begin
          if (count == '0) begin
            res_fire   = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            dumping_next = 1'b1;
            dcnt_next    = '0;
          end
        end
        default: begin
          // unknown opcode: no result, list untouched
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dumping <= 1'b0;
      dcnt    <= '0;
      done    <= 1'b0;
    end else begin
      count   <= count_next;
      dumping <= dumping_next;
      dcnt    <= dcnt_next;
      done    <= res_fire;
    end
  end

  // result payload, loaded only when an item is emitted
  always_ff @(posedge clk) begin
    if (res_fire) begin
      status    <= res_status;
      out_value <= res_value;
      out_index <= res_index;
      last      <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    accept && (opcode == OP_APPEND || opcode == OP_REMOVE) |=> done && last)
    else $error("append or remove gave no single result");

  a_dump_emits: assert property (@(posedge clk) disable iff (rst)
    dumping |=> done && $stable(count))
    else $error("dump cycle without a result or with a count change");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> last && out_value == '0 && out_index == '0)
    else $error("error result not final or not zeroed");

  a_dump_ends: assert property (@(posedge clk) disable iff (rst)
    dumping && dump_last |=> !dumping && last)
    else $error("dump did not finish on its final entry");
`endif

endmodule

// ----- sv/olar_cell.sv -----
module olar_cell (
  input  logic                        clk,
  input  olar_pkg::cell_cmd_t         cmd,
  input  logic [olar_pkg::CNT_W-1:0]  slot,
  input  logic signed [31:0]          next_value,
  input  logic signed [31:0]          wrap_value,
  output logic signed [31:0]          value
);
  import olar_pkg::*;

  logic signed [31:0] value_next;
  logic [CNT_W-1:0]   slot_plus;

  assign slot_plus = slot + CNT_W'(1);

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      CMD_APPEND: begin
        if (slot == cmd.count) value_next = cmd.data;
      end
      CMD_REMOVE: begin
        // entries after the removed one move up a place
        if (slot >= cmd.pos && slot_plus < cmd.count) value_next = next_value;
      end
      CMD_ROTATE: begin
        // occupied part of the chain turns by one, head goes to the tail
        if (slot_plus < cmd.count) value_next = next_value;
        else if (slot_plus == cmd.count) value_next = wrap_value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
